// ===== sv/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // widths fixed by the register map
    localparam int CFG_CNT_W  = 7;
    localparam int CFG_DATA_W = 32;
    localparam int FILL_W     = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_CNT_W-1:0] WINDOW_LEN_RESET = CFG_CNT_W'(3);

    // cells per group in the median select tree
    localparam int GROUP_SIZE = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH  = 2'd0,
        REG_PARTIAL_ENABLE = 2'd1,
        REG_LEAST_COUNT    = 2'd2,
        REG_FILL_VALUE     = 2'd3
    } swm_cfg_reg_t;

    typedef enum logic [1:0] {
        OP_IDLE    = 2'd0,
        OP_INSERT  = 2'd1,
        OP_DELETE  = 2'd2,
        OP_REPLACE = 2'd3
    } swm_op_t;

    // broadcast to every sorted cell each cycle
    typedef struct packed {
        swm_op_t op;
        logic    rep_up;   // replace with new sample >= departing sample
    } swm_cmd_t;

endpackage

`default_nettype wire

// ===== sv/swm_cell.sv =====
// One cell of the sorted chain: holds one sample and moves it to or from a neighbor.
// Depends on swm_pkg for the broadcast command.
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int CNT_W       = 7,
    parameter int IDX         = 0
) (
    input  wire logic                          aclk,
    input  wire swm_pkg::swm_cmd_t             cmd,
    input  wire logic [CNT_W-1:0]              count,
    input  wire logic signed [SAMPLE_BITS-1:0] s_val,
    input  wire logic signed [SAMPLE_BITS-1:0] v_val,
    input  wire logic signed [SAMPLE_BITS-1:0] left_val,
    input  wire logic                          left_gt,
    input  wire logic                          left_live,
    input  wire logic signed [SAMPLE_BITS-1:0] right_val,
    input  wire logic                          right_gt,
    input  wire logic                          right_live,
    output logic signed [SAMPLE_BITS-1:0]      val,
    output logic                               gt_s,
    output logic                               live
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic                          ge_v;
    logic                          le_v;

    assign live = (CNT_W'(IDX) < count);
    assign gt_s = (val_reg > s_val);
    assign ge_v = (val_reg >= v_val);
    assign le_v = (val_reg <= v_val);
    assign val  = val_reg;

    always_comb begin
        val_next = val_reg;
        unique case (cmd.op)
            OP_INSERT: begin
                // shift right past the new sample, first free cell takes the tail
                if ((live && gt_s) || (!live && left_live)) begin
                    val_next = (left_live && left_gt) ? left_val : s_val;
                end
            end
            OP_DELETE: begin
                if (live && ge_v) begin
                    val_next = right_val;
                end
            end
            OP_REPLACE: begin
                if (cmd.rep_up) begin
                    // close the gap leftward up to the new sample's slot
                    if (live && ge_v && !gt_s) begin
                        val_next = (right_live && !right_gt) ? right_val : s_val;
                    end
                end else begin
                    if (live && gt_s && le_v) begin
                        val_next = left_gt ? left_val : s_val;
                    end
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// ===== sv/swm_median.sv =====
// Median pick over the sorted chain: registered group select, then OR and add.
// Depends on swm_pkg for the group size.
`default_nettype none

module swm_median #(
    parameter int SAMPLE_BITS = 32,
    parameter int WINDOW_MAX  = 64,
    parameter int CNT_W       = 7
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [CNT_W-1:0]              held,
    input  wire logic signed [SAMPLE_BITS-1:0] vals [WINDOW_MAX],
    output logic signed [SAMPLE_BITS:0]        sum
);
    import swm_pkg::*;

    localparam int NG = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [CNT_W-1:0]       lo_idx;
    logic [CNT_W-1:0]       hi_idx;
    logic [SAMPLE_BITS-1:0] lo_grp_next [NG];
    logic [SAMPLE_BITS-1:0] hi_grp_next [NG];
    logic [SAMPLE_BITS-1:0] lo_grp_reg  [NG];
    logic [SAMPLE_BITS-1:0] hi_grp_reg  [NG];
    logic [SAMPLE_BITS-1:0] lo_all;
    logic [SAMPLE_BITS-1:0] hi_all;

    // lower and upper middle; the same cell when the count is odd
    assign lo_idx = (held - CNT_W'(1)) >> 1;
    assign hi_idx = held >> 1;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            lo_grp_next[g] = '0;
            hi_grp_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                if (g * GROUP_SIZE + j < WINDOW_MAX) begin
                    if (CNT_W'(g * GROUP_SIZE + j) == lo_idx) begin
                        lo_grp_next[g] = lo_grp_next[g] | vals[g * GROUP_SIZE + j];
                    end
                    if (CNT_W'(g * GROUP_SIZE + j) == hi_idx) begin
                        hi_grp_next[g] = hi_grp_next[g] | vals[g * GROUP_SIZE + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_grp_reg <= lo_grp_next;
            hi_grp_reg <= hi_grp_next;
        end
    end

    always_comb begin
        lo_all = '0;
        hi_all = '0;
        for (int g = 0; g < NG; g++) begin
            lo_all = lo_all | lo_grp_reg[g];
            hi_all = hi_all | hi_grp_reg[g];
        end
    end

    assign sum = (SAMPLE_BITS + 1)'(signed'(lo_all)) + (SAMPLE_BITS + 1)'(signed'(hi_all));

endmodule

`default_nettype wire

// ===== sv/sliding_window_median.sv =====
// Top level of the sliding-window median filter: handshakes, registers, arrival ring.
// Depends on swm_pkg, swm_cell and swm_median.
//
//  channel  direction  handshake              payload
//  s_       in         s_tvalid / s_tready    s_tdata: sample; s_tuser: series_start
//  m_       out        m_tvalid / m_tready    m_tdata: median_doubled; m_tuser: filled
//  cfg_     in         cfg_wr_en              cfg_index, cfg_data
//
// One sample per cycle when the held count is at or below the window and no output
// stall holds the pipeline; the sorted cell chain inserts and drops a sample in the
// same cycle. A result passes the cell update at the accepting edge, then the
// registered group select, then the output register, and a stall can hold it between.
// When the window shrinks, each held sample above the new window is dropped by a
// cell-chain delete before the next beat is taken. aresetn is synchronous;
// no clearing pass.
// A stalled output holds its beat while up to two more move through the pipeline.
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
    input  wire logic                                   s_tuser,  // series_start
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [((SAMPLE_BITS + 8) / 8) * 8-1:0]      m_tdata,  // median_doubled
    output logic                                        m_tuser,  // filled
    input  wire logic                                   cfg_wr_en,
    input  wire logic [swm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [swm_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int PTR_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
    localparam int OUT_W = SAMPLE_BITS + 1;
    localparam int M_W   = ((SAMPLE_BITS + 8) / 8) * 8;

    // configuration
    logic [CFG_CNT_W-1:0] wl_reg;
    logic                 pe_reg;
    logic [CFG_CNT_W-1:0] lc_reg;
    logic [FILL_W-1:0]    fill_reg;

    // window state
    logic [CNT_W-1:0]              held_reg, held_next;
    logic [CNT_W-1:0]              seen_reg, seen_next;
    logic [AW-1:0]                 wp_reg, wp_next;
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];

    // pipeline
    logic                 t1_valid_reg;
    logic                 t1_ready_reg;
    logic [CNT_W-1:0]     t1_held_reg;
    logic                 a_valid_reg;
    logic                 a_ready_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;
    logic                 m_filled_reg;

    logic                          a_en, b_en, step_en, prune, fire, replace, med_ready;
    logic [CMP_W-1:0]              wl_ext, win_ext;
    logic [CNT_W-1:0]              win, h0, cell_count;
    logic [AW-1:0]                 wp0, tail_next;
    logic [PTR_W-1:0]              wp_ext, h_ext, tail_ext;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [FILL_W:0]        fill_dbl;
    logic signed [OUT_W-1:0]       med_sum;
    swm_cmd_t                      cmd;

    logic signed [SAMPLE_BITS-1:0] cell_val  [WINDOW_MAX];
    logic                          cell_gt   [WINDOW_MAX];
    logic                          cell_live [WINDOW_MAX];

    assign sample = signed'(s_tdata[SAMPLE_BITS-1:0]);

    // effective window: zero acts as one, clamp at the chain length
    assign wl_ext  = CMP_W'(wl_reg);
    assign win_ext = (wl_ext == '0) ? CMP_W'(1) :
                     (wl_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : wl_ext;
    assign win     = CNT_W'(win_ext);

    // pipeline advance, output side first
    assign b_en     = a_valid_reg && (!m_valid_reg || m_tready);
    assign a_en     = t1_valid_reg && (!a_valid_reg || b_en);
    assign step_en  = !t1_valid_reg || a_en;
    assign prune    = step_en && (held_reg > win);
    assign s_tready = step_en && !(held_reg > win);
    assign fire     = s_tvalid && s_tready;

    assign h0      = s_tuser ? '0 : held_reg;
    assign wp0     = s_tuser ? '0 : wp_reg;
    assign replace = (h0 == win);

    always_comb begin
        cmd.op     = OP_IDLE;
        cmd.rep_up = (sample >= rd_reg);
        cell_count = held_reg;
        held_next  = held_reg;
        wp_next    = wp_reg;
        seen_next  = seen_reg;
        if (fire) begin
            cmd.op     = replace ? OP_REPLACE : OP_INSERT;
            cell_count = h0;
            held_next  = replace ? h0 : h0 + CNT_W'(1);
            wp_next    = (wp0 == AW'(WINDOW_MAX - 1)) ? '0 : wp0 + AW'(1);
            if (s_tuser) begin
                seen_next = CNT_W'(1);
            end else if (seen_reg != CNT_W'(WINDOW_MAX)) begin
                seen_next = seen_reg + CNT_W'(1);
            end
        end else if (prune) begin
            // drop the oldest sample
            cmd.op    = OP_DELETE;
            held_next = held_reg - CNT_W'(1);
        end
    end

    assign med_ready = (CMP_W'(seen_next) >= CMP_W'(win)) ||
                       (pe_reg && (CMP_W'(seen_next) >= CMP_W'(lc_reg)));

    // oldest live sample after this cycle's update
    assign wp_ext    = PTR_W'(wp_next);
    assign h_ext     = PTR_W'(held_next);
    assign tail_ext  = (wp_ext >= h_ext) ? wp_ext - h_ext
                                         : wp_ext + PTR_W'(WINDOW_MAX) - h_ext;
    assign tail_next = AW'(tail_ext);

    always_ff @(posedge aclk) begin
        if (fire) begin
            ring_mem[wp0] <= sample;
        end
        if (fire && (wp0 == tail_next)) begin
            rd_reg <= sample;
        end else begin
            rd_reg <= ring_mem[tail_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= WINDOW_LEN_RESET;
            pe_reg   <= 1'b0;
            lc_reg   <= '0;
            fill_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:  wl_reg   <= cfg_data[CFG_CNT_W-1:0];
                REG_PARTIAL_ENABLE: pe_reg   <= cfg_data[0];
                REG_LEAST_COUNT:    lc_reg   <= cfg_data[CFG_CNT_W-1:0];
                REG_FILL_VALUE:     fill_reg <= cfg_data[FILL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            seen_reg     <= '0;
            wp_reg       <= '0;
            t1_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            held_reg <= held_next;
            seen_reg <= seen_next;
            wp_reg   <= wp_next;
            if (fire) begin
                t1_valid_reg <= 1'b1;
            end else if (a_en) begin
                t1_valid_reg <= 1'b0;
            end
            if (a_en) begin
                a_valid_reg <= 1'b1;
            end else if (b_en) begin
                a_valid_reg <= 1'b0;
            end
            if (b_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign fill_dbl = signed'({fill_reg, 1'b0});

    always_ff @(posedge aclk) begin
        if (fire) begin
            t1_ready_reg <= med_ready;
            t1_held_reg  <= held_next;
        end
        if (a_en) begin
            a_ready_reg <= t1_ready_reg;
        end
        if (b_en) begin
            m_data_reg   <= a_ready_reg ? med_sum : OUT_W'(fill_dbl);
            m_filled_reg <= !a_ready_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] lv, rv;
            logic                          lg, ll, rg, rl;
            if (k == 0) begin : g_first
                assign lv = '0;
                assign lg = 1'b0;
                assign ll = 1'b1;
            end else begin : g_mid_l
                assign lv = cell_val[k-1];
                assign lg = cell_gt[k-1];
                assign ll = cell_live[k-1];
            end
            if (k == WINDOW_MAX - 1) begin : g_last
                assign rv = '0;
                assign rg = 1'b1;
                assign rl = 1'b0;
            end else begin : g_mid_r
                assign rv = cell_val[k+1];
                assign rg = cell_gt[k+1];
                assign rl = cell_live[k+1];
            end
            swm_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .CNT_W      (CNT_W),
                .IDX        (k)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .count     (cell_count),
                .s_val     (sample),
                .v_val     (rd_reg),
                .left_val  (lv),
                .left_gt   (lg),
                .left_live (ll),
                .right_val (rv),
                .right_gt  (rg),
                .right_live(rl),
                .val       (cell_val[k]),
                .gt_s      (cell_gt[k]),
                .live      (cell_live[k])
            );
        end
    endgenerate

    swm_median #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .WINDOW_MAX (WINDOW_MAX),
        .CNT_W      (CNT_W)
    ) u_median (
        .aclk(aclk),
        .en  (a_en),
        .held(t1_held_reg),
        .vals(cell_val),
        .sum (med_sum)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_W'($unsigned(m_data_reg));
    assign m_tuser  = m_filled_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(WINDOW_MAX))
        else $error("held count above chain length");

    a_cells_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (t1_valid_reg && !a_en) |=> ($stable(held_reg) && $stable(wp_reg)))
        else $error("window changed while its median was not yet picked");

    a_start_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (seen_reg == CNT_W'(1)))
        else $error("series start did not restart the seen count");

    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ((held_reg != '0) && (held_reg <= win)))
        else $error("held count outside window after a beat");
`endif

endmodule

`default_nettype wire
